### src/rsa_modexp_65537_montgomery_core_assert.svh
`ifndef RSA_MODEXP_65537_MONTGOMERY_CORE_ASSERT_SVH
`define RSA_MODEXP_65537_MONTGOMERY_CORE_ASSERT_SVH
// concurrent checks sampled on clk, off during reset
`define RSAME_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define RSAME_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`endif

### src/rsame_pkg.sv
package rsame_pkg;

  localparam int MAX_WORDS_DEF = 128;
  localparam int ADDR_W = 8;
  localparam int WORD_W = 32;
  localparam logic [4:0] LAST_PRODUCT = 5'd17;

  localparam logic [2:0] KIND_LOAD_N   = 3'd0;
  localparam logic [2:0] KIND_LOAD_R2  = 3'd1;
  localparam logic [2:0] KIND_LOAD_MSG = 3'd2;
  localparam logic [2:0] KIND_COMPUTE  = 3'd3;
  localparam logic [2:0] KIND_READ     = 3'd4;

  localparam logic CFG_WORDS = 1'b0;
  localparam logic CFG_NINV  = 1'b1;

  typedef enum logic [2:0] {
    MEM_N, MEM_R2, MEM_MSG, MEM_POW, MEM_SQ
  } mem_sel_t;

  typedef enum logic [3:0] {
    ENG_IDLE, ENG_XRD, ENG_XLAT, ENG_Q1, ENG_Q2, ENG_Q3, ENG_JRD, ENG_JCMP,
    ENG_JEND, ENG_SRD, ENG_SCMP, ENG_CRD, ENG_CCMP, ENG_NEXT
  } eng_state_t;

  typedef struct packed {
    mem_sel_t            src_sel;
    logic [ADDR_W-1:0]   src_addr;
    logic [ADDR_W-1:0]   n_addr;
    logic [ADDR_W-1:0]   de_raddr;
    logic                wr_en;
    mem_sel_t            wr_sel;
    logic [ADDR_W-1:0]   wr_addr;
    logic [WORD_W-1:0]   wr_data;
    logic                de_we;
    logic [ADDR_W-1:0]   de_waddr;
    logic [WORD_W-1:0]   d_wdata;
    logic [WORD_W-1:0]   e_wdata;
  } store_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] src_rdata;
    logic [WORD_W-1:0] n_rdata;
    logic [WORD_W-1:0] d_rdata;
    logic [WORD_W-1:0] e_rdata;
  } store_rsp_t;

  typedef struct packed {
    mem_sel_t x;
    mem_sel_t y;
    mem_sel_t res;
  } prod_sel_t;

  // to montgomery form, sixteen squarings, then times the plain message
  function automatic prod_sel_t product_sel(input logic [4:0] p);
    prod_sel_t s;
    if (p == 5'd0) begin
      s = '{x: MEM_MSG, y: MEM_R2, res: MEM_POW};
    end else if (p == LAST_PRODUCT) begin
      s = '{x: MEM_POW, y: MEM_MSG, res: MEM_POW};
    end else if (p[0]) begin
      s = '{x: MEM_POW, y: MEM_POW, res: MEM_SQ};
    end else begin
      s = '{x: MEM_SQ, y: MEM_SQ, res: MEM_POW};
    end
    return s;
  endfunction

endpackage

### src/rsame_store.sv
module rsame_store #(
  parameter int MAX_WORDS = rsame_pkg::MAX_WORDS_DEF
) (
  input  logic                  clk,
  input  rsame_pkg::store_req_t req,
  output rsame_pkg::store_rsp_t rsp
);
  localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

  logic [rsame_pkg::WORD_W-1:0] n_mem   [MAX_WORDS];
  logic [rsame_pkg::WORD_W-1:0] r2_mem  [MAX_WORDS];
  logic [rsame_pkg::WORD_W-1:0] msg_mem [MAX_WORDS];
  logic [rsame_pkg::WORD_W-1:0] pow_mem [MAX_WORDS];
  logic [rsame_pkg::WORD_W-1:0] sq_mem  [MAX_WORDS];
  logic [rsame_pkg::WORD_W-1:0] d_mem   [MAX_WORDS];
  logic [rsame_pkg::WORD_W-1:0] e_mem   [MAX_WORDS];

  logic [rsame_pkg::WORD_W-1:0] r2_q, msg_q, pow_q, sq_q, n_q, d_q, e_q;
  rsame_pkg::mem_sel_t          sel_q;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      case (req.wr_sel)
        rsame_pkg::MEM_N:   n_mem[AW'(req.wr_addr)]   <= req.wr_data;
        rsame_pkg::MEM_R2:  r2_mem[AW'(req.wr_addr)]  <= req.wr_data;
        rsame_pkg::MEM_MSG: msg_mem[AW'(req.wr_addr)] <= req.wr_data;
        rsame_pkg::MEM_POW: pow_mem[AW'(req.wr_addr)] <= req.wr_data;
        rsame_pkg::MEM_SQ:  sq_mem[AW'(req.wr_addr)]  <= req.wr_data;
        default: ;
      endcase
    end
    if (req.de_we) begin
      d_mem[AW'(req.de_waddr)] <= req.d_wdata;
      e_mem[AW'(req.de_waddr)] <= req.e_wdata;
    end
  end

  always_ff @(posedge clk) begin
    r2_q  <= r2_mem[AW'(req.src_addr)];
    msg_q <= msg_mem[AW'(req.src_addr)];
    pow_q <= pow_mem[AW'(req.src_addr)];
    sq_q  <= sq_mem[AW'(req.src_addr)];
    sel_q <= req.src_sel;
    n_q   <= n_mem[AW'(req.n_addr)];
    d_q   <= d_mem[AW'(req.de_raddr)];
    e_q   <= e_mem[AW'(req.de_raddr)];
  end

  always_comb begin
    rsp.n_rdata = n_q;
    rsp.d_rdata = d_q;
    rsp.e_rdata = e_q;
    case (sel_q)
      rsame_pkg::MEM_R2:  rsp.src_rdata = r2_q;
      rsame_pkg::MEM_MSG: rsp.src_rdata = msg_q;
      rsame_pkg::MEM_POW: rsp.src_rdata = pow_q;
      rsame_pkg::MEM_SQ:  rsp.src_rdata = sq_q;
      default:            rsp.src_rdata = '0;
    endcase
  end
endmodule

### src/rsame_engine.sv
module rsame_engine (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [7:0]            words,
  input  logic [31:0]           mu,
  input  rsame_pkg::store_rsp_t rsp,
  output rsame_pkg::store_req_t req,
  output logic                  busy
);
  rsame_pkg::eng_state_t state, state_next;
  rsame_pkg::prod_sel_t  sel;

  logic [4:0]  prod;
  logic [7:0]  i, j, wm1;
  logic [31:0] xi, ylo, d0, e0, n0, low, q, td, te;
  logic        cbit;
  logic [31:0] ymux, nmux, dj, ej, mmu_lo;
  logic [63:0] mxy, mqn, pd, pe;
  logic [32:0] diff, sum;

  assign sel  = rsame_pkg::product_sel(prod);
  assign wm1  = words - 8'd1;
  assign busy = (state != rsame_pkg::ENG_IDLE);

  assign ymux   = (state == rsame_pkg::ENG_Q3) ? ylo : rsp.src_rdata;
  assign nmux   = (state == rsame_pkg::ENG_Q3) ? n0 : rsp.n_rdata;
  assign mxy    = 64'(xi) * 64'(ymux);
  assign mqn    = 64'(q) * 64'(nmux);
  assign mmu_lo = mu * low;
  // first pass over a product: accumulators start at zero
  assign dj     = (i == 8'd0) ? 32'd0 : rsp.d_rdata;
  assign ej     = (i == 8'd0) ? 32'd0 : rsp.e_rdata;
  assign pd     = 64'(dj) + 64'(td) + mxy;
  assign pe     = 64'(ej) + 64'(te) + mqn;
  assign diff   = {1'b0, rsp.d_rdata} - {1'b0, rsp.e_rdata} - 33'(cbit);
  assign sum    = {1'b0, rsp.src_rdata} + {1'b0, rsp.n_rdata} + 33'(cbit);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rsame_pkg::ENG_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    req          = '0;
    req.src_sel  = sel.x;
    req.wr_sel   = sel.res;
    case (state)
      rsame_pkg::ENG_IDLE: if (start) state_next = rsame_pkg::ENG_XRD;
      rsame_pkg::ENG_XRD: begin
        req.src_addr = i;
        state_next   = rsame_pkg::ENG_XLAT;
      end
      rsame_pkg::ENG_XLAT: begin
        req.src_sel = sel.y;
        state_next  = rsame_pkg::ENG_Q1;
      end
      rsame_pkg::ENG_Q1: state_next = rsame_pkg::ENG_Q2;
      rsame_pkg::ENG_Q2: state_next = rsame_pkg::ENG_Q3;
      rsame_pkg::ENG_Q3: state_next = rsame_pkg::ENG_JRD;
      rsame_pkg::ENG_JRD: begin
        req.src_sel  = sel.y;
        req.src_addr = j;
        req.n_addr   = j;
        req.de_raddr = j;
        state_next   = rsame_pkg::ENG_JCMP;
      end
      rsame_pkg::ENG_JCMP: begin
        req.de_we    = 1'b1;
        req.de_waddr = j - 8'd1;
        req.d_wdata  = pd[31:0];
        req.e_wdata  = pe[31:0];
        state_next   = (j == wm1) ? rsame_pkg::ENG_JEND : rsame_pkg::ENG_JRD;
      end
      rsame_pkg::ENG_JEND: begin
        req.de_we    = 1'b1;
        req.de_waddr = wm1;
        req.d_wdata  = td;
        req.e_wdata  = te;
        state_next   = (i == wm1) ? rsame_pkg::ENG_SRD : rsame_pkg::ENG_XRD;
      end
      rsame_pkg::ENG_SRD: begin
        req.de_raddr = j;
        state_next   = rsame_pkg::ENG_SCMP;
      end
      rsame_pkg::ENG_SCMP: begin
        req.wr_en   = 1'b1;
        req.wr_addr = j;
        req.wr_data = diff[31:0];
        if (j != wm1) begin
          state_next = rsame_pkg::ENG_SRD;
        end else if (diff[32]) begin
          state_next = rsame_pkg::ENG_CRD;
        end else begin
          state_next = rsame_pkg::ENG_NEXT;
        end
      end
      rsame_pkg::ENG_CRD: begin
        req.src_sel  = sel.res;
        req.src_addr = j;
        req.n_addr   = j;
        state_next   = rsame_pkg::ENG_CCMP;
      end
      rsame_pkg::ENG_CCMP: begin
        req.wr_en   = 1'b1;
        req.wr_addr = j;
        req.wr_data = sum[31:0];
        state_next  = (j == wm1) ? rsame_pkg::ENG_NEXT : rsame_pkg::ENG_CRD;
      end
      rsame_pkg::ENG_NEXT: begin
        state_next = (prod == rsame_pkg::LAST_PRODUCT) ? rsame_pkg::ENG_IDLE
                                                       : rsame_pkg::ENG_XRD;
      end
      default: state_next = rsame_pkg::ENG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      rsame_pkg::ENG_IDLE: begin
        prod <= 5'd0;
        i    <= 8'd0;
      end
      rsame_pkg::ENG_XLAT: begin
        xi <= rsp.src_rdata;
        d0 <= dj;
        e0 <= ej;
        n0 <= rsp.n_rdata;
      end
      rsame_pkg::ENG_Q1: begin
        ylo <= rsp.src_rdata;
        low <= d0 - e0 + mxy[31:0];
      end
      rsame_pkg::ENG_Q2: q <= mmu_lo;
      rsame_pkg::ENG_Q3: begin
        td <= 32'((64'(d0) + mxy) >> 32);
        te <= 32'((64'(e0) + mqn) >> 32);
        j  <= 8'd1;
      end
      rsame_pkg::ENG_JCMP: begin
        td <= pd[63:32];
        te <= pe[63:32];
        j  <= j + 8'd1;
      end
      rsame_pkg::ENG_JEND: begin
        i    <= i + 8'd1;
        j    <= 8'd0;
        cbit <= 1'b0;
      end
      rsame_pkg::ENG_SCMP: begin
        cbit <= (j == wm1) ? 1'b0 : diff[32];
        j    <= (j == wm1) ? 8'd0 : j + 8'd1;
      end
      rsame_pkg::ENG_CCMP: begin
        cbit <= sum[32];
        j    <= j + 8'd1;
      end
      rsame_pkg::ENG_NEXT: begin
        prod <= prod + 5'd1;
        i    <= 8'd0;
      end
      default: ;
    endcase
  end
endmodule

### src/rsa_modexp_65537_montgomery_core.sv
// load beat: written to the selected store, next beat taken the following cycle
// read beat: store read registered, then result_word registered with out_valid, 1 read in flight
// compute beat: 18 montgomery products over W words, each a word-serial
//   multiply-accumulate loop on a single read port per store, followed
//   by a subtract pass and, on borrow, an add-back correction pass
// reset: words_in_use to 64, neg_modulus_inverse to 0; stores hold garbage
module rsa_modexp_65537_montgomery_core #(
  parameter int MAX_WORDS = rsame_pkg::MAX_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind,
  input  logic [6:0]  word_index,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] result_word,
  output logic [6:0]  result_index,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  logic [7:0]  words_in_use;
  logic [31:0] neg_modulus_inverse;
  logic        busy, start, in_beat, in_store, len_ok;
  logic        rd_pending, rd_inside;
  logic [6:0]  rd_index;

  rsame_pkg::store_req_t eng_req, top_req, req;
  rsame_pkg::store_rsp_t rsp;

  assign cfg_ready = 1'b1;
  assign in_store  = (32'(word_index) < MAX_WORDS);
  assign len_ok    = (words_in_use != 8'd0) && (words_in_use[3:0] == 4'd0) &&
                     (32'(words_in_use) <= MAX_WORDS);
  assign in_ready  = !busy && !rd_pending &&
                     !(out_valid && (kind == rsame_pkg::KIND_READ));
  assign in_beat   = in_valid && in_ready;
  assign start     = in_beat && (kind == rsame_pkg::KIND_COMPUTE) && len_ok;

  always_comb begin
    top_req          = '0;
    top_req.src_sel  = rsame_pkg::MEM_POW;
    top_req.src_addr = 8'(word_index);
    top_req.wr_addr  = 8'(word_index);
    top_req.wr_data  = value;
    top_req.wr_sel   = rsame_pkg::MEM_N;
    case (kind)
      rsame_pkg::KIND_LOAD_N:   top_req.wr_sel = rsame_pkg::MEM_N;
      rsame_pkg::KIND_LOAD_R2:  top_req.wr_sel = rsame_pkg::MEM_R2;
      rsame_pkg::KIND_LOAD_MSG: top_req.wr_sel = rsame_pkg::MEM_MSG;
      default:                  top_req.wr_sel = rsame_pkg::MEM_N;
    endcase
    top_req.wr_en = in_beat && in_store && ((kind == rsame_pkg::KIND_LOAD_N) ||
                    (kind == rsame_pkg::KIND_LOAD_R2) ||
                    (kind == rsame_pkg::KIND_LOAD_MSG));
    req = busy ? eng_req : top_req;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      words_in_use        <= 8'd64;
      neg_modulus_inverse <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rsame_pkg::CFG_WORDS: words_in_use        <= cfg_data[7:0];
        rsame_pkg::CFG_NINV:  neg_modulus_inverse <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_pending <= in_beat && (kind == rsame_pkg::KIND_READ);
      if (rd_pending) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      rd_index  <= word_index;
      rd_inside <= in_store;
    end
    if (rd_pending) begin
      result_word  <= rd_inside ? rsp.src_rdata : '0;
      result_index <= rd_index;
    end
  end

  rsame_engine u_engine (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .words (words_in_use),
    .mu    (32'd0 - neg_modulus_inverse),
    .rsp   (rsp),
    .req   (eng_req),
    .busy  (busy)
  );

  rsame_store #(
    .MAX_WORDS (MAX_WORDS)
  ) u_store (
    .clk (clk),
    .req (req),
    .rsp (rsp)
  );
endmodule

### src/rsame_checker.sv
`include "rsa_modexp_65537_montgomery_core_assert.svh"

module rsame_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [2:0]  kind,
  input logic [6:0]  word_index,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] result_word,
  input logic [6:0]  result_index
);
  `RSAME_ASSERT_IMPL(a_out_hold, out_valid && !out_ready, ##1 (out_valid && $stable(result_word) && $stable(result_index)), "result beat dropped or changed while stalled")
  `RSAME_ASSERT_IMPL(a_read_result, in_valid && in_ready && kind == rsame_pkg::KIND_READ, ##2 (out_valid && result_index == $past(word_index, 2)), "read beat gave no matching result")
  `RSAME_ASSERT_IMPL(a_no_spurious, $rose(out_valid), $past(in_valid && in_ready && kind == rsame_pkg::KIND_READ, 2), "result beat without a read")
endmodule

bind rsa_modexp_65537_montgomery_core rsame_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .kind         (kind),
  .word_index   (word_index),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .result_word  (result_word),
  .result_index (result_index)
);
